>>> hw/rtl/wrre_pkg.sv
// ----------------------------------------------------------------------------
// wrre_pkg
// shared types and constants of the water ripple refraction engine
// ----------------------------------------------------------------------------
`default_nettype none

package wrre_pkg;

  localparam int POS_W     = 6;
  localparam int HEIGHT_W  = 16;
  localparam int PIX_W     = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPLASH  = 2'd2;

  localparam logic [3:0]  DAMP_RESET   = 4'd4;
  localparam logic [2:0]  REFR_RESET   = 3'd3;
  localparam logic [14:0] SPLASH_RESET = 15'd4000;

  // pool texture
  localparam logic [15:0] COLOR_GROUT = 16'hDFFF;
  localparam logic [3:0]  TILE_MASK   = 4'hF;
  localparam logic [7:0]  G_BASE      = 8'd90;
  localparam logic [7:0]  B_BASE      = 8'd170;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_SPLASH = 2'd1,
    CMD_DROP   = 2'd2,
    CMD_RENDER = 2'd3
  } wrre_cmd_t;

  typedef struct packed {
    wrre_cmd_t            cmd;
    logic                 in_grid;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [HEIGHT_W-1:0]  drop_height;
  } wrre_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } wrre_bstat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_STEP_D,
    ST_SPLASH,
    ST_DROP,
    ST_REN_A,
    ST_REN_B,
    ST_REN_C,
    ST_REN_D,
    ST_DONE
  } wrre_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/wrre_in_if.sv
// ----------------------------------------------------------------------------
// wrre_in_if
// command channel: valid/ready with one command item
// ----------------------------------------------------------------------------
`default_nettype none

interface wrre_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [wrre_pkg::POS_W-1:0]    pos_x;
  logic [wrre_pkg::POS_W-1:0]    pos_y;
  logic [wrre_pkg::HEIGHT_W-1:0] drop_height;

  modport source (output valid, command, pos_x, pos_y, drop_height, input ready);
  modport sink   (input valid, command, pos_x, pos_y, drop_height, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wrre_out_if.sv
// ----------------------------------------------------------------------------
// wrre_out_if
// result channel: valid/ready with one pixel item
// ----------------------------------------------------------------------------
`default_nettype none

interface wrre_out_if;
  logic                       valid;
  logic                       ready;
  logic [wrre_pkg::PIX_W-1:0] pixel;
  logic [wrre_pkg::POS_W-1:0] column;
  logic                       last;

  modport source (output valid, pixel, column, last, input ready);
  modport sink   (input valid, pixel, column, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wrre_front.sv
// ----------------------------------------------------------------------------
// wrre_front
// accepts command items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module wrre_front #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  wrre_in_if.sink               in_ch,
  input  wrre_pkg::wrre_bstat_t bstat,
  output logic                  q_valid,
  output wrre_pkg::wrre_item_t  q_item
);
  import wrre_pkg::*;

  localparam int QD = 2;

  wrre_item_t qmem [QD];
  wrre_item_t item;
  logic       wp, rp;
  logic [1:0] count;
  logic       push;

  assign in_ch.ready = (count != 2'(QD)) && !bstat.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_item      = qmem[rp];

  // classify: bounds checks are settled here
  always_comb begin
    item.cmd         = wrre_cmd_t'(in_ch.command);
    item.pos_x       = in_ch.pos_x;
    item.pos_y       = in_ch.pos_y;
    item.drop_height = in_ch.drop_height;
    if (item.cmd == CMD_DROP) begin
      item.in_grid = (int'(in_ch.pos_x) < GRID_WIDTH) && (int'(in_ch.pos_y) < GRID_HEIGHT);
    end else begin
      item.in_grid = (int'(in_ch.pos_y) < GRID_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (bstat.pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(bstat.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= item;
  end

endmodule

`default_nettype wire

>>> hw/rtl/wrre_back.sv
// ----------------------------------------------------------------------------
// wrre_back
// executes queued commands on the two height memories and drives results
// ----------------------------------------------------------------------------
`default_nettype none

module wrre_back #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [wrre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wrre_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  q_valid,
  input  wrre_pkg::wrre_item_t                  q_item,
  output wrre_pkg::wrre_bstat_t                 bstat,
  wrre_out_if.source                            out_ch
);
  import wrre_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);

  function automatic logic [AW-1:0] addr_of(input int cx, input int cy);
    return AW'(cy * GRID_WIDTH + cx);
  endfunction

  function automatic logic [15:0] pool_color(input logic [3:0] px, input logic [3:0] py);
    logic [3:0] k;
    logic [7:0] g, b;
    k = (px + py) & TILE_MASK;
    g = G_BASE + 8'(k) * 8'd7;
    b = B_BASE + 8'(k) * 8'd5;
    if (px == 4'd0 || py == 4'd0) return COLOR_GROUT;
    return {5'd0, g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] chan(input logic [7:0] base, input logic signed [17:0] shade);
    logic signed [19:0] t;
    t = $signed(20'(base)) + (20'(shade) <<< 1);
    if (t < 0) return 8'd0;
    if (t > 20'sd255) return 8'd255;
    return t[7:0];
  endfunction

  wrre_state_t state, state_next;

  // configuration and buffer role
  logic [3:0]  ds;
  logic [2:0]  rs;
  logic [14:0] sh;
  logic        bsel;

  // sequencing
  wrre_item_t         cur;
  logic [XW-1:0]      x;
  logic [YW-1:0]      y;
  logic signed [2:0]  sdx, sdy;
  logic [AW-1:0]      caddr;

  // datapath registers
  logic signed [16:0] hsum;
  logic [15:0]        oldv, vreg;
  logic signed [16:0] ox, oy;

  // memories
  logic [15:0] mem0 [CELLS];
  logic [15:0] mem1 [CELLS];
  logic [15:0] q0a, q0b, q1a, q1b;
  logic [15:0] na, nb, oa;
  logic [AW-1:0] ra_n, rb_n, ra_o, wr_addr;
  logic [15:0]   wr_data;
  logic          wr_new, wr_old, wr_clr, we0, we1;

  // result register
  logic              ovalid, olast, ob_free, load_out;
  logic [PIX_W-1:0]  opix, pix_n;
  logic [POS_W-1:0]  ocol, col_n;
  logic              last_n;

  // derived values
  logic [AW-1:0]      a;
  logic               interior, step_last_col, step_last, splash_end, ren_last, clr_end;
  logic signed [7:0]  spx, spy;
  logic signed [5:0]  d2;
  logic               splash_hit;
  logic signed [17:0] sum18, sumr, half18, diff18;
  logic signed [16:0] dif_a;
  logic [15:0]        damped;
  logic signed [19:0] txs, tys;
  logic [3:0]         tx4, ty4;
  logic signed [17:0] shade;
  logic [15:0]        tex;
  logic [7:0]         rc, gc, bc;

  assign na = bsel ? q1a : q0a;
  assign nb = bsel ? q1b : q0b;
  assign oa = bsel ? q0a : q1a;

  assign a             = addr_of(int'(x), int'(y));
  assign interior      = (x != '0) && (int'(x) < GRID_WIDTH - 1) &&
                         (y != '0) && (int'(y) < GRID_HEIGHT - 1);
  assign step_last_col = (int'(x) == GRID_WIDTH - 2);
  assign step_last     = step_last_col && (int'(y) == GRID_HEIGHT - 2);
  assign splash_end    = (sdx == 3'sd3) && (sdy == 3'sd3);
  assign ren_last      = (int'(x) == GRID_WIDTH - 1);
  assign clr_end       = (caddr == AW'(CELLS - 1));

  assign spx        = $signed({2'b00, cur.pos_x}) + 8'(sdx);
  assign spy        = $signed({2'b00, cur.pos_y}) + 8'(sdy);
  assign d2         = 6'(sdx) * 6'(sdx) + 6'(sdy) * 6'(sdy);
  assign splash_hit = (d2 <= 6'sd9) && (spx >= 0) && (spx < GRID_WIDTH) &&
                      (spy >= 0) && (spy < GRID_HEIGHT);

  // wave update: half neighbour sum (rounded toward zero) minus older value
  assign sum18  = {hsum[16], hsum} + {{2{na[15]}}, na} + {{2{nb[15]}}, nb};
  assign sumr   = sum18 + $signed({17'd0, sum18[17]});
  assign half18 = sumr >>> 1;
  assign diff18 = half18 - {{2{oldv[15]}}, oldv};
  assign damped = vreg - 16'($signed(vreg) >>> ds);

  // slope of the newer grid
  assign dif_a = {na[15], na} - {nb[15], nb};

  // refracted texture lookup and shading
  assign txs   = $signed(20'(x)) + 20'(ox);
  assign tys   = $signed(20'(y)) + 20'(oy);
  assign shade = 18'(ox) + 18'(oy);

  always_comb begin
    if (txs < 0) tx4 = 4'd0;
    else if (txs > $signed(20'(GRID_WIDTH - 1))) tx4 = 4'(GRID_WIDTH - 1);
    else tx4 = txs[3:0];
    if (tys < 0) ty4 = 4'd0;
    else if (tys > $signed(20'(GRID_HEIGHT - 1))) ty4 = 4'(GRID_HEIGHT - 1);
    else ty4 = tys[3:0];
    tex = pool_color(tx4, ty4);
    rc  = chan({tex[15:11], 3'd0}, shade);
    gc  = chan({tex[10:5], 2'd0}, shade);
    bc  = chan({tex[4:0], 3'd0}, shade);
  end

  assign ob_free = !ovalid || out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_end) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.cmd)
            CMD_STEP:   state_next = ST_STEP_A;
            CMD_SPLASH: state_next = ST_SPLASH;
            CMD_DROP:   state_next = q_item.in_grid ? ST_DROP : ST_DONE;
            CMD_RENDER: state_next = q_item.in_grid ? ST_REN_A : ST_DONE;
          endcase
        end
      end
      ST_STEP_A: state_next = ST_STEP_B;
      ST_STEP_B: state_next = ST_STEP_C;
      ST_STEP_C: state_next = ST_STEP_D;
      ST_STEP_D: state_next = step_last ? ST_DONE : ST_STEP_A;
      ST_SPLASH: if (splash_end) state_next = ST_DONE;
      ST_DROP:   state_next = ST_DONE;
      ST_REN_A:  state_next = ST_REN_B;
      ST_REN_B:  state_next = ST_REN_C;
      ST_REN_C:  state_next = ST_REN_D;
      ST_REN_D:  if (ob_free) state_next = ren_last ? ST_IDLE : ST_REN_A;
      ST_DONE:   if (ob_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    ra_n     = a;
    rb_n     = a;
    ra_o     = a;
    wr_new   = 1'b0;
    wr_old   = 1'b0;
    wr_clr   = 1'b0;
    wr_addr  = a;
    wr_data  = 16'd0;
    bstat.pop      = 1'b0;
    bstat.clearing = 1'b0;
    load_out = 1'b0;
    pix_n    = '0;
    col_n    = '0;
    last_n   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        bstat.clearing = 1'b1;
        wr_clr  = 1'b1;
        wr_addr = caddr;
      end
      ST_IDLE:   bstat.pop = q_valid;
      ST_STEP_A: begin
        ra_n = a - AW'(1);
        rb_n = a + AW'(1);
      end
      ST_STEP_B: begin
        ra_n = a - AW'(GRID_WIDTH);
        rb_n = a + AW'(GRID_WIDTH);
      end
      ST_STEP_C: ;
      ST_STEP_D: begin
        wr_old  = 1'b1;
        wr_data = damped;
      end
      ST_SPLASH: begin
        wr_new  = splash_hit;
        wr_addr = addr_of(int'(spx), int'(spy));
        wr_data = {1'b0, sh};
      end
      ST_DROP: begin
        wr_new  = 1'b1;
        wr_addr = addr_of(int'(cur.pos_x), int'(cur.pos_y));
        wr_data = cur.drop_height;
      end
      ST_REN_A: begin
        if (interior) begin
          ra_n = a - AW'(1);
          rb_n = a + AW'(1);
        end
      end
      ST_REN_B: begin
        if (interior) begin
          ra_n = a - AW'(GRID_WIDTH);
          rb_n = a + AW'(GRID_WIDTH);
        end
      end
      ST_REN_C: ;
      ST_REN_D: begin
        load_out = ob_free;
        pix_n    = {rc[7:3], gc[7:2], bc[7:3]};
        col_n    = POS_W'(x);
        last_n   = ren_last;
      end
      ST_DONE:   load_out = ob_free;
      default: ;
    endcase
  end

  assign we0 = wr_clr || (wr_new && !bsel) || (wr_old && bsel);
  assign we1 = wr_clr || (wr_new && bsel) || (wr_old && !bsel);

  always_ff @(posedge clk) begin
    if (we0) mem0[wr_addr] <= wr_data;
    q0a <= mem0[bsel ? ra_o : ra_n];
    q0b <= mem0[rb_n];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wr_addr] <= wr_data;
    q1a <= mem1[bsel ? ra_n : ra_o];
    q1b <= mem1[rb_n];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      caddr  <= '0;
      bsel   <= 1'b0;
      ds     <= DAMP_RESET;
      rs     <= REFR_RESET;
      sh     <= SPLASH_RESET;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) caddr <= caddr + AW'(1);
      if (state == ST_STEP_D && step_last) bsel <= ~bsel;
      if (cfg_we) begin
        if (cfg_index == REG_DAMPING) ds <= cfg_data[3:0];
        if (cfg_index == REG_REFRACT) rs <= cfg_data[2:0];
        if (cfg_index == REG_SPLASH)  sh <= cfg_data;
      end
      if (load_out) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

  // sequencing and datapath registers
  always_ff @(posedge clk) begin
    if (bstat.pop) begin
      cur <= q_item;
      sdx <= -3'sd3;
      sdy <= -3'sd3;
      if (q_item.cmd == CMD_STEP) begin
        x <= XW'(1);
        y <= YW'(1);
      end else begin
        x <= '0;
        y <= YW'(int'(q_item.pos_y));
      end
    end
    if (state == ST_STEP_B) begin
      hsum <= {na[15], na} + {nb[15], nb};
      oldv <= oa;
    end
    if (state == ST_STEP_C) vreg <= diff18[15:0];
    if (state == ST_STEP_D) begin
      if (step_last_col) begin
        x <= XW'(1);
        y <= y + YW'(1);
      end else begin
        x <= x + XW'(1);
      end
    end
    if (state == ST_SPLASH) begin
      if (sdx == 3'sd3) begin
        sdx <= -3'sd3;
        sdy <= sdy + 3'sd1;
      end else begin
        sdx <= sdx + 3'sd1;
      end
    end
    if (state == ST_REN_B) ox <= interior ? (dif_a >>> rs) : 17'sd0;
    if (state == ST_REN_C) oy <= interior ? (dif_a >>> rs) : 17'sd0;
    if (state == ST_REN_D && ob_free && !ren_last) x <= x + XW'(1);
    if (load_out) begin
      opix  <= pix_n;
      ocol  <= col_n;
      olast <= last_n;
    end
  end

  assign out_ch.valid  = ovalid;
  assign out_ch.pixel  = opix;
  assign out_ch.column = ocol;
  assign out_ch.last   = olast;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !bstat.pop)
    else $error("queue popped during clearing pass");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> ob_free)
    else $error("result register overwritten while full");

  a_no_write_in_render: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REN_A || state == ST_REN_B || state == ST_REN_C || state == ST_REN_D)
    |-> !(we0 || we1))
    else $error("memory written during render");

  a_swap_after_step: assert property (@(posedge clk) disable iff (rst)
    (bsel != $past(bsel)) |-> ($past(state) == ST_STEP_D))
    else $error("buffer role changed outside a step");

endmodule

`default_nettype wire

>>> hw/rtl/water_ripple_refraction_engine.sv
// ----------------------------------------------------------------------------
// water_ripple_refraction_engine
// two-grid water ripple simulation with refracted pool rendering
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    command, pos_x, pos_y, drop_height
//  out_ch    out   valid / ready    pixel, column, last
//  cfg       in    cfg_we only      cfg_index, cfg_data
//
//  step: states STEP_A to STEP_D for each interior cell, bound by the single
//    write port and the two read ports of each height memory
//  render: W items, REN_A to REN_D per pixel, held while out_ch stalls
//  reset: a clearing pass zeroes both memories, in_ch.ready low
//  a two-entry command queue and the result register let each side stall alone
//
`default_nettype none

module water_ripple_refraction_engine #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wrre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wrre_pkg::CFG_W-1:0]     cfg_data,
  wrre_in_if.sink                        in_ch,
  wrre_out_if.source                     out_ch
);
  import wrre_pkg::*;

  // queue between front and back
  logic        q_valid;
  wrre_item_t  q_item;
  // back end status: pop of the queue head, clearing pass in progress
  wrre_bstat_t bstat;

  // front: accept, bounds classification, queue
  wrre_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .bstat   (bstat),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // back: height memories, wave update, splash/drop writes, renderer
  wrre_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .bstat     (bstat),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
